### hw/rtl/bti_pkg.sv
// ---------------------------------------------------------------------------
// bti_pkg
// Shared types and constants for the breakpoint table interpolator.
// ---------------------------------------------------------------------------
package bti_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_FWD    = 2'd1;
    localparam logic [1:0] REQ_INV    = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LOW       = 3'd1;
    localparam logic [2:0] ST_HIGH      = 3'd2;
    localparam logic [2:0] ST_ABOVE_ONE = 3'd3;
    localparam logic [2:0] ST_ORDER     = 3'd4;
    localparam logic [2:0] ST_INDEX     = 3'd5;

    localparam logic [16:0] ONE_Q15 = 17'd32768;
    localparam logic signed [15:0] FLOOR_SNIR = -16'sd25600;

    // one entry travelling along the cell chain
    typedef struct packed {
        logic signed [15:0] snir;
        logic        [15:0] info;
    } bp_t;

endpackage

### hw/rtl/bti_cell.sv
// ---------------------------------------------------------------------------
// bti_cell
// One storage cell of the breakpoint chain: holds an entry, rotates it to
// its neighbor on shift, takes a new entry on load.
// ---------------------------------------------------------------------------
module bti_cell
    import bti_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  logic load,
    input  bp_t  load_data,
    input  bp_t  prev_data,
    output bp_t  data
);

    bp_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
        else if (shift)
            data_reg <= prev_data;
    end

    assign data = data_reg;

endmodule

### hw/rtl/bti_div.sv
// ---------------------------------------------------------------------------
// bti_div
// Serial signed divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
module bti_div
    import bti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] num,
    input  logic        [16:0] den,
    output logic               done,
    output logic signed [33:0] quot
);

    logic [33:0] rem_reg, rem_next;
    logic [33:0] q_reg, q_next;
    logic [16:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [34:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (busy_reg)
        begin
            trial = {rem_reg, q_reg[33]} - {18'd0, den_reg};
            if (!trial[34])
            begin
                rem_next = trial[33:0];
                q_next   = {q_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[32:0], q_reg[33]};
                q_next   = {q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd34;
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num[33] ? 34'(-num) : num;
            neg_reg <= num[33];
            den_reg <= den;
        end
        else
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

### hw/rtl/breakpoint_table_interpolator.sv
// ---------------------------------------------------------------------------
// breakpoint_table_interpolator
// Piecewise-linear SNIR/information table held in a rotating chain of cells.
// Sequence: a load or unused request makes one rotation of the chain, then
// raises out_valid; a query makes the rotation, registers the product and
// divisor, starts the divider, runs its 34-step divide, then raises out_valid.
// One request is in flight at a time: the next is accepted only after the
// result has been taken.
// Reset: control clears, table_length reads 1; table entries stay undefined.
// ---------------------------------------------------------------------------
module breakpoint_table_interpolator
    import bti_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [5:0]         entry_index,
    input  logic signed [15:0] entry_snir_db,
    input  logic [15:0]        entry_information,
    input  logic signed [15:0] query_snir_db,
    input  logic [15:0]        query_information,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        information_out,
    output logic signed [15:0] snir_db_out,
    output logic [2:0]         status
);

    localparam int CW = $clog2(MAX_POINTS) + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_WAIT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    logic [6:0] len_reg;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] pos_reg;      // index of entry now at the chain head
    logic [1:0] req_reg;
    logic [5:0] idx_reg;
    logic signed [15:0] es_reg;
    logic [15:0] ei_reg;
    logic signed [15:0] qs_reg;
    logic [16:0] qi_reg;
    bp_t prev_reg, lo_reg, hi_reg, first_reg, last_reg;
    logic found_reg;
    logic signed [33:0] prod_reg;
    logic [16:0] den_reg;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0] dd;
    logic div_start;
    logic div_done;
    logic signed [33:0] quot;
    logic [15:0] info_o_reg;
    logic signed [15:0] snir_o_reg;
    logic [2:0] st_reg;

    bp_t chain [MAX_POINTS];
    bp_t head;
    logic shift;
    bp_t new_entry;
    logic [15:0] ysat;
    logic load_hit;
    logic load_ok;
    logic wr_now;
    logic scan_live;

    assign head = chain[0];
    assign n_eff = (len_reg == 7'd0) ? CW'(1) :
                   ({25'd0, len_reg} > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(len_reg);
    assign shift = (state_reg == S_SCAN);

    // replace the entry at the head as it rotates into the last cell
    assign ysat = (ei_reg > ONE_Q15[15:0]) ? ONE_Q15[15:0] : ei_reg;
    assign new_entry = {es_reg, ysat};
    assign load_hit = (req_reg == REQ_LOAD) && ({26'd0, idx_reg} == 32'(pos_reg))
                      && ({26'd0, idx_reg} < 32'(n_eff));
    assign load_ok = ($signed(es_reg) > $signed(prev_reg.snir)) && (ysat >= prev_reg.info);
    assign wr_now = shift && load_hit && load_ok;
    assign scan_live = (pos_reg != '0) && (pos_reg < n_eff) && !found_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++)
        begin : g_cell
            bti_cell u_cell (
                .clk       (clk),
                .shift     (shift),
                .load      ((g == MAX_POINTS - 1) && wr_now),
                .load_data (new_entry),
                .prev_data (chain[(g + 1) % MAX_POINTS]),
                .data      (chain[g])
            );
        end
    endgenerate

    always_comb
    begin
        if (req_reg == REQ_FWD)
        begin
            dx = {qs_reg[15], qs_reg} - {lo_reg.snir[15], lo_reg.snir};
            dy = {1'b0, hi_reg.info} - {1'b0, lo_reg.info};
            dd = {hi_reg.snir[15], hi_reg.snir} - {lo_reg.snir[15], lo_reg.snir};
        end
        else
        begin
            dx = qi_reg - {1'b0, lo_reg.info};
            dy = {hi_reg.snir[15], hi_reg.snir} - {lo_reg.snir[15], lo_reg.snir};
            dd = {1'b0, hi_reg.info} - {1'b0, lo_reg.info};
        end
    end

    bti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign information_out = info_o_reg;
    assign snir_db_out = snir_o_reg;
    assign status = st_reg;
    assign div_start = (state_reg == S_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= 7'd1;
            pos_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_SCAN;
                        pos_reg   <= '0;
                    end
                S_SCAN:
                begin
                    pos_reg <= pos_reg + CW'(1);
                    if (pos_reg == CW'(MAX_POINTS - 1))
                        state_reg <= (req_reg == REQ_FWD || req_reg == REQ_INV) ? S_WAIT
                                                                                : S_OUT;
                end
                S_WAIT: state_reg <= S_MUL;
                S_MUL:  state_reg <= S_DIV;
                S_DIV:  if (div_done) state_reg <= S_OUT;
                S_OUT:  if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    req_reg    <= req_type;
                    idx_reg    <= entry_index;
                    es_reg     <= entry_snir_db;
                    ei_reg     <= entry_information;
                    qs_reg     <= query_snir_db;
                    qi_reg     <= {1'b0, query_information};
                    found_reg  <= 1'b0;
                    prev_reg   <= {FLOOR_SNIR, 16'd0};
                    info_o_reg <= '0;
                    snir_o_reg <= '0;
                    if (req_type == REQ_LOAD && {26'd0, entry_index} >= 32'(n_eff))
                        st_reg <= ST_INDEX;
                    else
                        st_reg <= ST_OK;
                end
            S_SCAN:
            begin
                prev_reg <= head;
                if (pos_reg == '0)
                    first_reg <= head;
                if (pos_reg == n_eff - CW'(1))
                    last_reg <= head;
                if (load_hit && !load_ok)
                    st_reg <= ST_ORDER;
                // first entry at or above the query, searched from entry 1
                if (scan_live)
                begin
                    if ((req_reg == REQ_FWD && $signed(qs_reg) <= $signed(head.snir)) ||
                        (req_reg == REQ_INV && qi_reg <= {1'b0, head.info}))
                    begin
                        found_reg <= 1'b1;
                        lo_reg    <= prev_reg;
                        hi_reg    <= head;
                    end
                end
            end
            S_WAIT:
            begin
                prod_reg <= dx * dy;
                den_reg  <= dd;
            end
            S_DIV:
                if (div_done)
                begin
                    if (req_reg == REQ_FWD)
                    begin
                        if ($signed(qs_reg) < $signed(first_reg.snir))
                            st_reg <= ST_LOW;
                        else if (!found_reg)
                        begin
                            info_o_reg <= ONE_Q15[15:0];
                            st_reg     <= ST_HIGH;
                        end
                        else if (hi_reg.snir == lo_reg.snir)
                            info_o_reg <= lo_reg.info;
                        else
                            info_o_reg <= lo_reg.info + quot[15:0];
                    end
                    else
                    begin
                        if (qi_reg < {1'b0, first_reg.info})
                        begin
                            snir_o_reg <= first_reg.snir;
                            st_reg     <= ST_LOW;
                        end
                        else if (qi_reg > ONE_Q15)
                        begin
                            snir_o_reg <= last_reg.snir;
                            st_reg     <= ST_ABOVE_ONE;
                        end
                        else if (qi_reg > {1'b0, last_reg.info})
                        begin
                            snir_o_reg <= last_reg.snir;
                            st_reg     <= ST_HIGH;
                        end
                        else if (qi_reg == {1'b0, first_reg.info})
                            snir_o_reg <= first_reg.snir;
                        else
                            snir_o_reg <= lo_reg.snir + quot[15:0];
                    end
                end
            default: ;
        endcase
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid));
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(information_out)
                                    && $stable(snir_db_out) && $stable(status));
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_INDEX);

endmodule
